[hdl/x86ea_pkg.sv]
// Package: shared types and constants for the x86 effective address block
`timescale 1ns / 1ps
package x86ea_pkg;

    localparam int NumGeneral = 8;
    localparam int NumSegment = 6;

    localparam logic [2:0]  NoOverride = 3'd6;
    localparam logic [2:0]  SegEs      = 3'd0;
    localparam logic [2:0]  SegCs      = 3'd1;
    localparam logic [2:0]  SegSs      = 3'd2;
    localparam logic [2:0]  SegDs      = 3'd3;
    localparam logic [15:0] CsResetVal = 16'hF000;

    localparam logic [2:0] GrEsp = 3'd4;
    localparam logic [2:0] GrEbp = 3'd5;
    localparam logic [2:0] GrEbx = 3'd3;
    localparam logic [2:0] GrEsi = 3'd6;
    localparam logic [2:0] GrEdi = 3'd7;

    localparam logic [1:0] ModNoDisp  = 2'd0;
    localparam logic [1:0] ModDisp8   = 2'd1;
    localparam logic [1:0] ModDispFul = 2'd2;
    localparam logic [1:0] ModReg     = 2'd3;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_COMPUTE = 1'b1
    } command_t;

    typedef struct packed {
        command_t    command;
        logic [3:0]  reg_select;
        logic [31:0] reg_value;
        logic        address_size32;
        logic [7:0]  modrm_byte;
        logic [7:0]  sib_byte;
        logic [31:0] displacement;
        logic [2:0]  segment_override;
    } ea_in_t;

    typedef struct packed {
        logic [15:0] segment_value;
        logic [31:0] offset;
        logic [32:0] linear_address;
        logic [2:0]  bytes_consumed;
        logic        status;
    } ea_out_t;

    typedef logic [NumGeneral-1:0][31:0] gpr_file_t;
    typedef logic [NumSegment-1:0][15:0] seg_file_t;

endpackage

[hdl/x86ea_addr_calc.sv]
// Combinational ModR/M and SIB address decode and offset calculation
`timescale 1ns / 1ps
module x86ea_addr_calc
    import x86ea_pkg::*;
(
    input  ea_in_t    item,
    input  gpr_file_t gpr,
    input  seg_file_t seg,
    output ea_out_t   result
);

    logic [1:0]  mode;
    logic [2:0]  rm;
    logic [1:0]  scale;
    logic [2:0]  index;
    logic [2:0]  base;
    logic [15:0] base16;
    logic [15:0] disp16;
    logic [15:0] off16;
    logic [31:0] disp32;
    logic [31:0] index_val;
    logic [31:0] base_val;
    logic [31:0] off32;
    logic [2:0]  consumed;
    logic [2:0]  seg_idx;
    logic [2:0]  seg_sel;
    logic [15:0] seg_val;

    assign mode  = item.modrm_byte[7:6];
    assign rm    = item.modrm_byte[2:0];
    assign scale = item.sib_byte[7:6];
    assign index = item.sib_byte[5:3];
    assign base  = item.sib_byte[2:0];

    always_comb begin
        base16    = '0;
        disp16    = '0;
        disp32    = '0;
        index_val = '0;
        base_val  = '0;
        consumed  = '0;
        seg_idx   = SegDs;
        off16     = '0;
        off32     = '0;
        if (!item.address_size32) begin
            case (mode)
                ModDisp8: begin
                    disp16   = {{8{item.displacement[7]}}, item.displacement[7:0]};
                    consumed = 3'd1;
                end
                ModDispFul: begin
                    disp16   = item.displacement[15:0];
                    consumed = 3'd2;
                end
                default: begin
                    disp16   = '0;
                    consumed = 3'd0;
                end
            endcase
            case (rm)
                3'd0: base16 = gpr[GrEbx][15:0] + gpr[GrEsi][15:0];
                3'd1: base16 = gpr[GrEbx][15:0] + gpr[GrEdi][15:0];
                3'd2: begin
                    base16  = gpr[GrEbp][15:0] + gpr[GrEsi][15:0];
                    seg_idx = SegSs;
                end
                3'd3: begin
                    base16  = gpr[GrEbp][15:0] + gpr[GrEdi][15:0];
                    seg_idx = SegSs;
                end
                3'd4: base16 = gpr[GrEsi][15:0];
                3'd5: base16 = gpr[GrEdi][15:0];
                3'd6: begin
                    if (mode == ModNoDisp) begin
                        disp16   = item.displacement[15:0];
                        consumed = 3'd2;
                        base16   = '0;
                    end else begin
                        base16  = gpr[GrEbp][15:0];
                        seg_idx = SegSs;
                    end
                end
                default: base16 = gpr[GrEbx][15:0];
            endcase
            off16 = base16 + disp16;
            off32 = {16'h0000, off16};
        end else begin
            case (mode)
                ModDisp8: begin
                    disp32   = {{24{item.displacement[7]}}, item.displacement[7:0]};
                    consumed = 3'd1;
                end
                ModDispFul: begin
                    disp32   = item.displacement;
                    consumed = 3'd4;
                end
                default: begin
                    disp32   = '0;
                    consumed = 3'd0;
                end
            endcase
            if (rm == GrEsp) begin
                index_val = (index == GrEsp) ? 32'h0 : (gpr[index] << scale);
                consumed  = consumed + 3'd1;
                if (base == GrEbp && mode == ModNoDisp) begin
                    disp32   = item.displacement;
                    consumed = consumed + 3'd4;
                    base_val = '0;
                end else begin
                    base_val = gpr[base];
                    if (base == GrEsp || base == GrEbp) begin
                        seg_idx = SegSs;
                    end
                end
            end else if (rm == GrEbp && mode == ModNoDisp) begin
                disp32   = item.displacement;
                consumed = 3'd4;
            end else begin
                base_val = gpr[rm];
                if (rm == GrEbp) begin
                    seg_idx = SegSs;
                end
            end
            off32 = index_val + base_val + disp32;
        end
    end

    assign seg_sel = (item.segment_override < NoOverride) ? item.segment_override : seg_idx;
    assign seg_val = seg[seg_sel];

    always_comb begin
        result = '0;
        if (item.command == CMD_COMPUTE) begin
            if (mode == ModReg) begin
                result.status = 1'b1;
            end else begin
                result.segment_value  = seg_val;
                result.offset         = off32;
                result.linear_address = {1'b0, 12'h000, seg_val, 4'h0} + {1'b0, off32};
                result.bytes_consumed = consumed;
            end
        end
    end

endmodule

[hdl/x86_modrm_effective_address.sv]
// Top level: register file, input stage and result stage of the address generator
//
// Usage:
//   s_valid/s_ready/s_item carry one command per transfer: a register load
//   (EAX..EDI, ES..GS) or an effective address computation from ModR/M,
//   SIB and displacement bytes. m_valid/m_ready/m_item return exactly one
//   result per command; a load returns an all-zero result.
//   From input transfer to result valid a command passes through the input
//   register, then the address adder and segment select into the result
//   register. Throughput is one command per cycle while m_ready is high; the
//   address path is a single three-operand add plus the segment shift-add.
//   A load updates the register file as it leaves the input register, so a
//   compute in the next cycle already sees the new value.
//   Reset clears all general registers and segments, except CS = 0xF000,
//   and empties both stages. When m_ready is low the result holds, the
//   input register still fills once, and s_ready drops after that.
`timescale 1ns / 1ps
module x86_modrm_effective_address
    import x86ea_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ea_in_t  s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output ea_out_t m_item
);

    ea_in_t    in_reg;
    logic      in_valid_reg;
    ea_out_t   out_reg;
    logic      out_valid_reg;
    gpr_file_t gpr_reg;
    seg_file_t seg_reg;
    seg_file_t seg_reset;
    ea_out_t   result_next;
    logic      advance;
    logic      load_en;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign load_en = advance && (in_reg.command == CMD_LOAD);

    always_comb begin
        seg_reset        = '0;
        seg_reset[SegCs] = CsResetVal;
    end

    x86ea_addr_calc u_calc (
        .item   (in_reg),
        .gpr    (gpr_reg),
        .seg    (seg_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gpr_reg <= '0;
            seg_reg <= seg_reset;
        end else if (load_en) begin
            if (!in_reg.reg_select[3]) begin
                gpr_reg[in_reg.reg_select[2:0]] <= in_reg.reg_value;
            end else if (in_reg.reg_select[2:0] < NoOverride) begin
                seg_reg[in_reg.reg_select[2:0]] <= in_reg.reg_value[15:0];
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

[hdl/x86ea_checker.sv]
// Port checker for the address generator and its bind to the top level
`timescale 1ns / 1ps
module x86ea_checker
    import x86ea_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input ea_in_t  s_item,
    input logic    m_valid,
    input logic    m_ready,
    input ea_out_t m_item
);

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted transfer did not reach the result stage");

    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result stage");

    a_linear_sum : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.status |->
            m_item.linear_address ==
            ({1'b0, 12'h000, m_item.segment_value, 4'h0} + {1'b0, m_item.offset}))
        else $error("linear address does not match segment and offset");

endmodule

bind x86_modrm_effective_address x86ea_checker u_x86ea_checker (.*);

[verif/ea_result_checker.sv]
// Checker: tracks register loads, computes each effective address and compares results
`timescale 1ns / 1ps
module ea_result_checker
    import x86ea_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_ready,
    input  ea_in_t  s_item,
    input  logic    m_valid,
    input  logic    m_ready,
    input  ea_out_t m_item,
    output int      fail_count,
    output int      pending
);

    localparam logic [2:0] Rm16BxSi = 3'd0;
    localparam logic [2:0] Rm16BxDi = 3'd1;
    localparam logic [2:0] Rm16BpSi = 3'd2;
    localparam logic [2:0] Rm16BpDi = 3'd3;
    localparam logic [2:0] Rm16Si   = 3'd4;
    localparam logic [2:0] Rm16Di   = 3'd5;
    localparam logic [2:0] Rm16Bp   = 3'd6;
    localparam logic [2:0] RmSib    = 3'd4;
    localparam logic [2:0] RmDisp32 = 3'd5;
    localparam logic [2:0] SibNoIdx = 3'd4;
    localparam logic [2:0] SibNoBas = 3'd5;

    logic [31:0] gpr [NumGeneral];
    logic [15:0] sgr [NumSegment];
    ea_out_t     expected_ea_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [31:0] lo16(input logic [2:0] r);
        return {16'b0, gpr[r][15:0]};
    endfunction

    function automatic ea_out_t effective_address(input ea_in_t it);
        ea_out_t     r;
        logic [1:0]  md;
        logic [2:0]  rm;
        logic [2:0]  idx;
        logic [2:0]  bs;
        logic [2:0]  seg_sel;
        logic [2:0]  used;
        logic [31:0] d;
        logic [31:0] a;
        logic [31:0] off;
        logic [15:0] sv;
        r = '0;
        if (it.command == CMD_LOAD) return r;
        md = it.modrm_byte[7:6];
        rm = it.modrm_byte[2:0];
        if (md == ModReg) begin
            r.status = 1'b1;
            return r;
        end
        seg_sel = SegDs;
        used    = '0;
        d       = '0;
        off     = '0;
        if (md == ModDisp8) begin
            d    = {{24{it.displacement[7]}}, it.displacement[7:0]};
            used = 3'd1;
        end
        if (!it.address_size32) begin
            if (md == ModDispFul) begin
                d    = {16'b0, it.displacement[15:0]};
                used = 3'd2;
            end
            case (rm)
                Rm16BxSi: off = lo16(GrEbx) + lo16(GrEsi);
                Rm16BxDi: off = lo16(GrEbx) + lo16(GrEdi);
                Rm16BpSi: begin
                    off     = lo16(GrEbp) + lo16(GrEsi);
                    seg_sel = SegSs;
                end
                Rm16BpDi: begin
                    off     = lo16(GrEbp) + lo16(GrEdi);
                    seg_sel = SegSs;
                end
                Rm16Si: off = lo16(GrEsi);
                Rm16Di: off = lo16(GrEdi);
                Rm16Bp: begin
                    if (md == ModNoDisp) begin
                        d    = {16'b0, it.displacement[15:0]};
                        used = 3'd2;
                    end else begin
                        off     = lo16(GrEbp);
                        seg_sel = SegSs;
                    end
                end
                default: off = lo16(GrEbx);
            endcase
            off = off + d;
            off = {16'b0, off[15:0]};
        end else begin
            if (md == ModDispFul) begin
                d    = it.displacement;
                used = 3'd4;
            end
            if (rm == RmSib) begin
                idx  = it.sib_byte[5:3];
                bs   = it.sib_byte[2:0];
                a    = (idx == SibNoIdx) ? 32'b0 : gpr[idx];
                a    = a << it.sib_byte[7:6];
                used = used + 3'd1;
                if (bs == SibNoBas && md == ModNoDisp) begin
                    d    = it.displacement;
                    used = used + 3'd4;
                end else begin
                    a = a + gpr[bs];
                    if (bs == GrEsp || bs == GrEbp) seg_sel = SegSs;
                end
                off = a + d;
            end else if (rm == RmDisp32 && md == ModNoDisp) begin
                off  = it.displacement;
                used = 3'd4;
            end else begin
                off = gpr[rm] + d;
                if (rm == GrEbp) seg_sel = SegSs;
            end
        end
        if (it.segment_override < NoOverride) seg_sel = it.segment_override;
        sv = sgr[seg_sel];
        r.segment_value  = sv;
        r.offset         = off;
        r.linear_address = {13'b0, sv, 4'b0} + {1'b0, off};
        r.bytes_consumed = used;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        ea_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < NumGeneral; i++) gpr[i] = '0;
            for (int i = 0; i < NumSegment; i++) sgr[i] = '0;
            sgr[SegCs] = CsResetVal;
            expected_ea_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_ea_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_item));
                end else begin
                    want = expected_ea_q.pop_front();
                    if (m_item.segment_value !== want.segment_value)
                        report_mismatch($sformatf("segment_value got %h expected %h",
                            m_item.segment_value, want.segment_value));
                    if (m_item.offset !== want.offset)
                        report_mismatch($sformatf("offset got %h expected %h",
                            m_item.offset, want.offset));
                    if (m_item.linear_address !== want.linear_address)
                        report_mismatch($sformatf("linear_address got %h expected %h",
                            m_item.linear_address, want.linear_address));
                    if (m_item.bytes_consumed !== want.bytes_consumed)
                        report_mismatch($sformatf("bytes_consumed got %0d expected %0d",
                            m_item.bytes_consumed, want.bytes_consumed));
                    if (m_item.status !== want.status)
                        report_mismatch($sformatf("status got %b expected %b",
                            m_item.status, want.status));
                end
            end
            if (s_valid && s_ready) begin
                expected_ea_q.push_back(effective_address(s_item));
                if (s_item.command == CMD_LOAD) begin
                    if (s_item.reg_select < NumGeneral)
                        gpr[s_item.reg_select[2:0]] = s_item.reg_value;
                    else if (s_item.reg_select < NumGeneral + NumSegment)
                        sgr[s_item.reg_select[2:0]] = s_item.reg_value[15:0];
                end
            end
        end
        pending <= expected_ea_q.size();
    end

endmodule

[verif/tb.sv]
// Testbench top: clock, reset, command stimulus, result backpressure and verdict
`timescale 1ns / 1ps
module tb;
    import x86ea_pkg::*;

    localparam int NumRandom  = 2000;
    localparam int CycleLimit = 200000;

    localparam logic [3:0] SelEbx = 4'd3;
    localparam logic [3:0] SelEsp = 4'd4;
    localparam logic [3:0] SelEbp = 4'd5;
    localparam logic [3:0] SelEsi = 4'd6;
    localparam logic [3:0] SelEs  = 4'd8;
    localparam logic [3:0] SelCs  = 4'd9;
    localparam logic [3:0] SelSs  = 4'd10;
    localparam logic [3:0] SelGs  = 4'd13;
    localparam logic [3:0] SelNone14 = 4'd14;
    localparam logic [3:0] SelNone15 = 4'd15;
    localparam logic [2:0] OvrUnused = 3'd7;
    localparam logic [2:0] SegGs     = 3'd5;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    ea_in_t  s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    ea_out_t m_item;
    int      fail_count;
    int      pending;
    int      cycle_count = 0;
    int      s_idle_pct  = 32;
    int      m_idle_pct  = 72;

    always #5 aclk = ~aclk;

    x86_modrm_effective_address i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    ea_result_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("** x86_modrm_effective_address: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic ea_in_t rand_item();
        ea_in_t it;
        it.command          = ($urandom_range(3) == 0) ? CMD_LOAD : CMD_COMPUTE;
        it.reg_select       = 4'($urandom_range(15));
        it.reg_value        = rand_word();
        it.address_size32   = 1'($urandom_range(1));
        it.modrm_byte       = 8'($urandom_range(255));
        it.sib_byte         = 8'($urandom_range(255));
        it.displacement     = rand_word();
        it.segment_override = 3'($urandom_range(7));
        return it;
    endfunction

    function automatic ea_in_t load_item(input logic [3:0] sel, input logic [31:0] val);
        ea_in_t it;
        it            = rand_item();
        it.command    = CMD_LOAD;
        it.reg_select = sel;
        it.reg_value  = val;
        return it;
    endfunction

    function automatic ea_in_t ea_item(input logic a32, input logic [7:0] modrm,
                                       input logic [7:0] sib, input logic [31:0] disp,
                                       input logic [2:0] ovr);
        ea_in_t it;
        it                  = rand_item();
        it.command          = CMD_COMPUTE;
        it.address_size32   = a32;
        it.modrm_byte       = modrm;
        it.sib_byte         = sib;
        it.displacement     = disp;
        it.segment_override = ovr;
        return it;
    endfunction

    task automatic send_item(input ea_in_t it);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            s_item  <= rand_item();
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        ea_in_t directed [$];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(load_item(SelEbx, 32'hFFFF_FFFF));
        directed.push_back(load_item(SelEsi, 32'h8000_0001));
        directed.push_back(load_item(SelEbp, 32'h0000_FFFF));
        directed.push_back(load_item(SelEsp, 32'h7FFF_FFF0));
        directed.push_back(load_item(SelEs, 32'hDEAD_1234));
        directed.push_back(load_item(SelSs, 32'h0000_FFFF));
        directed.push_back(load_item(SelGs, 32'h0000_ABCD));
        directed.push_back(load_item(SelNone14, 32'hFFFF_FFFF));
        directed.push_back(load_item(SelNone15, 32'h1234_5678));
        directed.push_back(ea_item(1'b0, 8'b00_000_000, 8'h00, 32'h0, NoOverride));
        directed.push_back(ea_item(1'b0, 8'b00_000_110, 8'h00, 32'hFFFF_FFFF, OvrUnused));
        directed.push_back(ea_item(1'b0, 8'b01_000_010, 8'h00, 32'h0000_0080, NoOverride));
        directed.push_back(ea_item(1'b0, 8'b10_000_110, 8'h00, 32'h0000_FFFF, NoOverride));
        directed.push_back(ea_item(1'b0, 8'b11_000_000, 8'h00, 32'h1234_5678, NoOverride));
        directed.push_back(ea_item(1'b1, 8'b00_000_101, 8'h00, 32'hFFFF_FFFF, NoOverride));
        directed.push_back(ea_item(1'b1, 8'b00_000_100, 8'b00_100_101, 32'h1234_5678,
                                   NoOverride));
        directed.push_back(ea_item(1'b1, 8'b01_000_100, 8'b11_110_100, 32'h0000_00FF,
                                   NoOverride));
        directed.push_back(ea_item(1'b1, 8'b10_000_100, 8'b01_011_101, 32'h8000_0000,
                                   OvrUnused));
        directed.push_back(ea_item(1'b1, 8'b01_000_101, 8'h00, 32'h0000_007F, NoOverride));
        directed.push_back(ea_item(1'b1, 8'b00_000_011, 8'h00, 32'h0, SegEs));
        directed.push_back(ea_item(1'b1, 8'b11_111_111, 8'hFF, 32'hFFFF_FFFF, NoOverride));
        directed.push_back(ea_item(1'b0, 8'b00_000_111, 8'h00, 32'h0, SegGs));
        directed.push_back(ea_item(1'b1, 8'b10_000_000, 8'h00, 32'hFFFF_FFFF, SegCs));
        directed.push_back(load_item(SelCs, 32'h0000_0000));

        foreach (directed[i]) send_item(directed[i]);

        for (int i = 0; i < NumRandom; i++) begin
            if (i == NumRandom / 3) begin
                s_idle_pct = 72;
                m_idle_pct = 32;
            end else if (i == 2 * NumRandom / 3) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            send_item(rand_item());
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("** x86_modrm_effective_address: PASSED **");
        end else begin
            $display("** x86_modrm_effective_address: FAILED **");
        end
        $finish;
    end

endmodule

[x86_modrm_effective_address.f]
hdl/x86ea_pkg.sv
hdl/x86ea_addr_calc.sv
hdl/x86_modrm_effective_address.sv
hdl/x86ea_checker.sv
verif/ea_result_checker.sv
verif/tb.sv
